[rtl/block_matrix_word_alu_macros.svh]
// Assertion macros shared by the RTL of the block matrix word ALU.
`ifndef BLOCK_MATRIX_WORD_ALU_MACROS_SVH
`define BLOCK_MATRIX_WORD_ALU_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BMWA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BMWA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/bmwa_pkg.sv]
// Types and constants of the block matrix word ALU.
`timescale 1ns / 1ps
`default_nettype none
package bmwa_pkg;
  localparam int WORD_W  = 32;
  localparam int CELLS   = 16;
  localparam int ADDR_W  = 4;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [ADDR_W-1:0] addr_t;

  localparam logic [4:0] MD_LOAD_OPND = 5'd0;
  localparam logic [4:0] MD_LOAD_WORK = 5'd1;
  localparam logic [4:0] MD_MMUL      = 5'd2;
  localparam logic [4:0] MD_XOR       = 5'd3;
  localparam logic [4:0] MD_ADD       = 5'd4;
  localparam logic [4:0] MD_SUB       = 5'd5;
  localparam logic [4:0] MD_ROW_UP    = 5'd6;
  localparam logic [4:0] MD_ROW_DOWN  = 5'd7;
  localparam logic [4:0] MD_COL_LEFT  = 5'd8;
  localparam logic [4:0] MD_COL_RIGHT = 5'd9;
  localparam logic [4:0] MD_CELL_LEFT = 5'd10;
  localparam logic [4:0] MD_CELL_RIGHT = 5'd11;
  localparam logic [4:0] MD_BITS_LEFT = 5'd12;
  localparam logic [4:0] MD_BITS_RIGHT = 5'd13;
  localparam logic [4:0] MD_GET_BIT   = 5'd14;
  localparam logic [4:0] MD_SET_BIT   = 5'd15;
  localparam logic [4:0] MD_FLIP_BIT  = 5'd16;
  localparam logic [4:0] MD_READ      = 5'd17;
  localparam logic [4:0] MD_CLEAR     = 5'd18;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_COPY,
    ST_OP,
    ST_CHECK,
    ST_DONE
  } state_t;
endpackage
`default_nettype wire

[rtl/bmwa_ram.sv]
// Sixteen-word block memory with one write port and two registered read ports.
`timescale 1ns / 1ps
`default_nettype none
module bmwa_ram
  import bmwa_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  we,
  input  wire addr_t waddr,
  input  wire word_t wdata,
  input  wire addr_t ra_addr,
  output word_t      ra_data,
  input  wire addr_t rb_addr,
  output word_t      rb_data
);
  word_t mem [CELLS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    ra_data <= mem[ra_addr];
    rb_data <= mem[rb_addr];
  end
endmodule
`default_nettype wire

[rtl/block_matrix_word_alu.sv]
// Top level of the block matrix word ALU: sequencer around the block memories.
// Loads, reads and unused modes go straight to the check sweep; set, flip, xor,
// add, sub and clear run an operation sweep first; rotations first copy the work
// block, as does the matrix product, which runs one multiplier over 64 products.
// A new word is taken in the cycle after the strobe; the receiver cannot stall.
// After reset a clearing pass zeroes both blocks while busy is high.
`timescale 1ns / 1ps
`default_nettype none
`include "block_matrix_word_alu_macros.svh"
module block_matrix_word_alu
  import bmwa_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [4:0]  in_mode,
  input  wire logic [3:0]  in_word_index,
  input  wire logic [31:0] in_word_value,
  input  wire logic [8:0]  in_bit_index,
  input  wire logic        in_bit_value,
  output logic             out_valid,
  output logic [31:0]      out_word_out,
  output logic             out_bit_out,
  output logic             out_blocks_equal
);
  state_t state_r, state_nxt;
  logic [6:0] cnt_r, cnt_nxt;
  logic [6:0] op_len;
  logic       dv_r;
  logic [5:0] dcnt_r;
  logic       issue;

  logic [4:0] mode_r;
  addr_t      widx_r;
  logic [8:0] bidx_r;
  logic       bval_r;
  word_t      word_r;
  logic       bit_r;
  logic       eq_r;
  word_t      acc_r;

  logic       w_we, o_we, t_we;
  addr_t      w_waddr, o_waddr, t_waddr;
  word_t      w_wdata, o_wdata, t_wdata;
  addr_t      w_raddr, o_raddr, t_raddr_a, t_raddr_b;
  word_t      w_rdata, o_rdata, t_rdata_a, t_rdata_b;

  addr_t      bw;
  logic [4:0] bpos;
  word_t      prod;
  word_t      acc_sum;
  logic       accept;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);
  assign bw     = bidx_r[8:5];
  assign bpos   = 5'd31 - bidx_r[4:0];
  assign prod   = t_rdata_a * o_rdata;
  assign acc_sum = ((dcnt_r[1:0] == 2'd0) ? '0 : acc_r) + prod;

  assign out_valid        = (state_r == ST_DONE);
  assign out_word_out     = word_r;
  assign out_bit_out      = bit_r;
  assign out_blocks_equal = eq_r;

  always_comb begin
    case (mode_r)
      MD_MMUL:                                   op_len = 7'd64;
      MD_SET_BIT, MD_FLIP_BIT:                   op_len = 7'd1;
      default:                                   op_len = 7'd16;
    endcase
  end

  bmwa_ram u_work (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
    .ra_addr(w_raddr), .ra_data(w_rdata), .rb_addr(w_raddr), .rb_data()
  );
  bmwa_ram u_opnd (
    .clk(clk), .we(o_we), .waddr(o_waddr), .wdata(o_wdata),
    .ra_addr(o_raddr), .ra_data(o_rdata), .rb_addr(o_raddr), .rb_data()
  );
  bmwa_ram u_copy (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .ra_addr(t_raddr_a), .ra_data(t_rdata_a), .rb_addr(t_raddr_b), .rb_data(t_rdata_b)
  );

  // Next state and sweep counter.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r + 7'd1;
    case (state_r)
      ST_INIT: begin
        if (cnt_r == 7'd15) begin
          state_nxt = ST_IDLE;
          cnt_nxt   = '0;
        end
      end
      ST_IDLE: begin
        cnt_nxt = '0;
        if (start) begin
          case (in_mode)
            MD_MMUL, MD_ROW_UP, MD_ROW_DOWN, MD_COL_LEFT, MD_COL_RIGHT,
            MD_CELL_LEFT, MD_CELL_RIGHT, MD_BITS_LEFT, MD_BITS_RIGHT:
              state_nxt = ST_COPY;
            MD_XOR, MD_ADD, MD_SUB, MD_SET_BIT, MD_FLIP_BIT, MD_CLEAR:
              state_nxt = ST_OP;
            default:
              state_nxt = ST_CHECK;
          endcase
        end
      end
      ST_COPY: begin
        if (cnt_r == 7'd16) begin
          state_nxt = ST_OP;
          cnt_nxt   = '0;
        end
      end
      ST_OP: begin
        if (cnt_r == op_len) begin
          state_nxt = ST_CHECK;
          cnt_nxt   = '0;
        end
      end
      ST_CHECK: begin
        if (cnt_r == 7'd16) begin
          state_nxt = ST_DONE;
          cnt_nxt   = '0;
        end
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
        cnt_nxt   = '0;
      end
      default: begin
        state_nxt = ST_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  // Memory addressing and write-back.
  always_comb begin
    logic [1:0] r, c, k;
    addr_t i, di, src;
    word_t res;
    r = cnt_r[1:0];
    c = cnt_r[3:2];
    k = cnt_r[1:0];
    i = cnt_r[3:0];
    di = dcnt_r[3:0];
    src = i;
    res = '0;
    issue     = 1'b0;
    w_we = 1'b0; w_waddr = '0; w_wdata = '0;
    o_we = 1'b0; o_waddr = '0; o_wdata = '0;
    t_we = 1'b0; t_waddr = di; t_wdata = w_rdata;
    w_raddr = i; o_raddr = i; t_raddr_a = i; t_raddr_b = i;
    case (mode_r)
      MD_ROW_UP:                    src = {c, r + 2'd1};
      MD_ROW_DOWN:                  src = {c, r - 2'd1};
      MD_COL_LEFT:                  src = {c + 2'd1, r};
      MD_COL_RIGHT:                 src = {c - 2'd1, r};
      MD_CELL_LEFT, MD_BITS_LEFT:   src = i + 4'd1;
      MD_CELL_RIGHT, MD_BITS_RIGHT: src = i - 4'd1;
      default:                      src = i;
    endcase
    case (mode_r)
      MD_XOR:        res = w_rdata ^ o_rdata;
      MD_ADD:        res = w_rdata + o_rdata;
      MD_SUB:        res = w_rdata - o_rdata;
      MD_BITS_LEFT:  res = {t_rdata_a[WORD_W-2:0], t_rdata_b[WORD_W-1]};
      MD_BITS_RIGHT: res = {t_rdata_b[0], t_rdata_a[WORD_W-1:1]};
      MD_SET_BIT: begin
        res = w_rdata;
        res[bpos] = bval_r;
      end
      MD_FLIP_BIT: begin
        res = w_rdata;
        res[bpos] = ~w_rdata[bpos];
      end
      MD_MMUL:       res = acc_sum;
      default:       res = t_rdata_b;
    endcase
    case (state_r)
      ST_INIT: begin
        w_we = 1'b1; w_waddr = i;
        o_we = 1'b1; o_waddr = i;
      end
      ST_IDLE: begin
        if (start && (in_mode == MD_LOAD_WORK)) begin
          w_we = 1'b1; w_waddr = in_word_index; w_wdata = in_word_value;
        end
        if (start && (in_mode == MD_LOAD_OPND)) begin
          o_we = 1'b1; o_waddr = in_word_index; o_wdata = in_word_value;
        end
      end
      ST_COPY: begin
        issue = (cnt_r < 7'd16);
        t_we  = dv_r;
      end
      ST_OP: begin
        issue = (cnt_r < op_len);
        if (mode_r == MD_MMUL) begin
          t_raddr_a = {k, cnt_r[3:2]};
          o_raddr   = {cnt_r[5:4], k};
          w_we      = dv_r && (dcnt_r[1:0] == 2'd3);
          w_waddr   = dcnt_r[5:2];
          w_wdata   = res;
        end else if ((mode_r == MD_SET_BIT) || (mode_r == MD_FLIP_BIT)) begin
          w_raddr = bw;
          w_we    = dv_r;
          w_waddr = bw;
          w_wdata = res;
        end else if (mode_r == MD_CLEAR) begin
          w_we    = issue;
          w_waddr = i;
        end else begin
          t_raddr_b = src;
          w_we      = dv_r;
          w_waddr   = di;
          w_wdata   = res;
        end
      end
      ST_CHECK: begin
        issue = (cnt_r < 7'd16);
      end
      default: begin
        issue = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      cnt_r   <= '0;
      dv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      dv_r    <= issue;
    end
  end

  always_ff @(posedge clk) begin
    dcnt_r <= cnt_r[5:0];
    if (accept) begin
      mode_r <= in_mode;
      widx_r <= in_word_index;
      bidx_r <= in_bit_index;
      bval_r <= in_bit_value;
    end
    if ((state_r == ST_OP) && dv_r) begin
      acc_r <= acc_sum;
    end
    if ((state_r == ST_CHECK) && dv_r) begin
      eq_r <= ((dcnt_r == 6'd0) || eq_r) && (w_rdata == o_rdata);
      if (dcnt_r[3:0] == widx_r) begin
        word_r <= w_rdata;
      end
      if (dcnt_r[3:0] == bw) begin
        bit_r <= w_rdata[bpos];
      end
    end
  end

  `BMWA_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid, "result strobe held too long")
  `BMWA_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy, "not busy after accept")
  `BMWA_ASSERT_SAME(a_strobe_busy, out_valid, busy, "result shown while idle")
  `BMWA_ASSERT_SAME(a_done_drained, state_r == ST_DONE, !dv_r, "read in flight at result")
endmodule
`default_nettype wire
